@@ hdl/ila_pkg.sv @@
// ----------------------------------------------------------------------------
// ila_pkg
// shared types and constants for the interrupt line allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ila_pkg;

    localparam int LINE_COUNT = 16;
    localparam int LINE_W     = $clog2(LINE_COUNT);
    localparam int COUNT_W    = $clog2(LINE_COUNT + 1);

    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    localparam logic [7:0]            AUTO_REQUEST    = 8'hFF;
    localparam logic [LINE_COUNT-1:0] RESERVED_SET    = 16'h2005;
    localparam logic [LINE_COUNT-1:0] CASCADE_BIT     = 16'h0004;
    localparam logic [LINE_COUNT-1:0] RESET_MASK_WORD = 16'hFFFB;
    localparam logic [COUNT_W-1:0]    RESET_COUNT     = 5'd3;

    typedef enum logic [1:0] {
        CMD_ALLOCATE = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_MASK     = 2'd2,
        CMD_UNMASK   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_RESERVED  = 3'd2,
        ST_USED      = 3'd3,
        ST_NONE_FREE = 3'd4,
        ST_NOT_ALLOC = 3'd5
    } status_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic [7:0]  line_request;
        command_t    command;
    } in_word_t;

    typedef struct packed {
        logic [3:0]            pad;
        logic [COUNT_W-1:0]    allocated_count;
        logic [LINE_COUNT-1:0] line_mask;
        logic [LINE_W-1:0]     granted_line;
        status_t               status;
    } out_word_t;

endpackage

`default_nettype wire

@@ hdl/interrupt_line_allocator_top.sv @@
// ----------------------------------------------------------------------------
// interrupt_line_allocator_top
// allocate, free, mask and unmask sixteen interrupt lines, one word per command
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   16     command [1:0], line_request [9:2]
//  m_axis    out  32     status [2:0], granted_line [6:3], line_mask [22:7],
//                        allocated_count [27:23]
//
//  one command per cycle while results are taken; a word waits in the input register and
//  then lands in the result register with the line flags updated in the same cycle
//  a command passes the input register, then the result register, before its output handshake
//  reset marks lines 0, 2 and 13 used and masked, mask word 0xFFFB
//  a stalled result holds the input register, which holds s_axis_tready low
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_line_allocator_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // command, line_request

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // status, granted_line, line_mask,
                                             // allocated_count
);

    localparam int N = ila_pkg::LINE_COUNT;
    localparam int LW = ila_pkg::LINE_W;
    localparam int CW = ila_pkg::COUNT_W;

    // input stage
    logic               in_valid_reg;
    ila_pkg::in_word_t  in_word_reg;

    // line state
    logic [N-1:0]       line_used_reg,   line_used_next;
    logic [N-1:0]       line_masked_reg, line_masked_next;
    logic [N-1:0]       mask_word_reg,   mask_word_next;
    logic [CW-1:0]      used_count_reg,  used_count_next;

    // result stage
    logic               out_valid_reg;
    ila_pkg::out_word_t out_word_reg, out_word_next;

    logic               advance;
    logic [7:0]         req;
    logic [LW-1:0]      line;
    logic [N-1:0]       line_bit;
    logic               in_range;
    logic               is_reserved;
    logic               is_used;
    logic [N-1:0]       free_set;
    logic [LW-1:0]      first_free;
    logic               any_free;
    logic [LW-1:0]      alloc_line;
    logic [N-1:0]       alloc_bit;
    ila_pkg::status_t   status;
    logic [LW-1:0]      granted;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign req         = in_word_reg.line_request;
    assign line        = req[LW-1:0];
    assign line_bit    = N'(1) << line;
    assign in_range    = (req < 8'(N));
    assign is_reserved = ila_pkg::RESERVED_SET[line];
    assign is_used     = line_used_reg[line];

    assign free_set = ~line_used_reg & ~ila_pkg::RESERVED_SET;
    assign any_free = |free_set;

    // lowest free line: scan from the top so the lowest hit wins
    always_comb
    begin
        first_free = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (free_set[i])
            begin
                first_free = LW'(i);
            end
        end
    end

    assign alloc_line = (req == ila_pkg::AUTO_REQUEST) ? first_free : line;
    assign alloc_bit  = N'(1) << alloc_line;

    always_comb
    begin
        line_used_next   = line_used_reg;
        line_masked_next = line_masked_reg;
        used_count_next  = used_count_reg;
        status           = ila_pkg::ST_OK;
        granted          = '0;

        case (in_word_reg.command)
            ila_pkg::CMD_ALLOCATE:
            begin
                if (req == ila_pkg::AUTO_REQUEST && !any_free)
                begin
                    status = ila_pkg::ST_NONE_FREE;
                end
                else if (req != ila_pkg::AUTO_REQUEST && !in_range)
                begin
                    status = ila_pkg::ST_RANGE;
                end
                else if (req != ila_pkg::AUTO_REQUEST && is_reserved)
                begin
                    status = ila_pkg::ST_RESERVED;
                end
                else if (req != ila_pkg::AUTO_REQUEST && is_used)
                begin
                    status = ila_pkg::ST_USED;
                end
                else
                begin
                    line_used_next   = line_used_reg | alloc_bit;
                    line_masked_next = line_masked_reg & ~alloc_bit;
                    used_count_next  = CW'(used_count_reg + CW'(1));
                    granted          = alloc_line;
                end
            end
            ila_pkg::CMD_FREE:
            begin
                if (!in_range)
                begin
                    status = ila_pkg::ST_RANGE;
                end
                else if (!is_used)
                begin
                    status = ila_pkg::ST_NOT_ALLOC;
                end
                else if (is_reserved)
                begin
                    status = ila_pkg::ST_RESERVED;
                end
                else
                begin
                    line_used_next   = line_used_reg & ~line_bit;
                    line_masked_next = line_masked_reg | line_bit;
                    used_count_next  = CW'(used_count_reg - CW'(1));
                end
            end
            ila_pkg::CMD_MASK:
            begin
                if (!in_range)
                begin
                    status = ila_pkg::ST_RANGE;
                end
                else
                begin
                    line_masked_next = line_masked_reg | line_bit;
                end
            end
            default:
            begin
                if (!in_range)
                begin
                    status = ila_pkg::ST_RANGE;
                end
                else if (is_reserved)
                begin
                    status = ila_pkg::ST_RESERVED;
                end
                else
                begin
                    line_masked_next = line_masked_reg & ~line_bit;
                end
            end
        endcase

        // every successful command goes through a mask or unmask
        if (status == ila_pkg::ST_OK)
        begin
            mask_word_next = line_masked_next | ila_pkg::CASCADE_BIT;
        end
        else
        begin
            mask_word_next = mask_word_reg;
        end
    end

    always_comb
    begin
        out_word_next                 = '0;
        out_word_next.status          = status;
        out_word_next.granted_line    = granted;
        out_word_next.line_mask       = mask_word_next;
        out_word_next.allocated_count = used_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            line_used_reg   <= ila_pkg::RESERVED_SET;
            line_masked_reg <= ila_pkg::RESERVED_SET;
            mask_word_reg   <= ila_pkg::RESET_MASK_WORD;
            used_count_reg  <= ila_pkg::RESET_COUNT;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                line_used_reg   <= line_used_next;
                line_masked_reg <= line_masked_next;
                mask_word_reg   <= mask_word_next;
                used_count_reg  <= used_count_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_word_reg <= ila_pkg::in_word_t'(s_axis_tdata);
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;

`ifndef NO_ASSERTIONS
    // the running count tracks the used flags
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg == CW'($countones(line_used_reg)))
        else $error("used count out of step with used flags");

    // reserved lines never leave the used or masked set
    a_reserved_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((line_used_reg & ila_pkg::RESERVED_SET) == ila_pkg::RESERVED_SET) &&
        ((line_masked_reg & ila_pkg::RESERVED_SET) == ila_pkg::RESERVED_SET))
        else $error("reserved line released or unmasked");

    // the cascade line reads as disabled once the mask word has been rebuilt
    a_cascade_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_word_reg == ila_pkg::RESET_MASK_WORD) ||
        ((mask_word_reg & ila_pkg::CASCADE_BIT) != '0))
        else $error("cascade bit clear in mask word");

    // a failed command grants no line
    a_grant_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_word_reg.status != ila_pkg::ST_OK)
            |-> (out_word_reg.granted_line == '0))
        else $error("line granted on a failed command");

    // a processed command shows up as a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("processed command left no result");
`endif

endmodule

`default_nettype wire
